FILE: sv/gas_pkg.sv
// Shared command and status types for the greedy activity selection block.
`default_nettype none

package gas_pkg;

    typedef struct packed {
        logic load;
        logic start_scan;
        logic rd;
        logic chk;
        logic emit_final;
        logic finish;
    } gas_cmd_t;

    typedef struct packed {
        logic match;
        logic pend_valid;
        logic scan_done;
        logic scan_end;
        logic out_taken;
    } gas_sts_t;

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_RD   = 5'b00010,
        S_CHK  = 5'b00100,
        S_WAIT = 5'b01000,
        S_LAST = 5'b10000
    } gas_state_t;

endpackage

`default_nettype wire

FILE: sv/greedy_activity_selection.sv
// Top level of the greedy activity selection block.
// Activities are loaded at one beat per cycle into a store of MAX_ACTIVITIES
// entries; a beat with last_item set closes the set of n stored
// activities and starts the selection walk, during which the input is stalled.
// The walk visits every (finish value, stored entry) pair for finish values
// below 2*n; each visit is one registered read of the store followed by one
// compare, and the walk holds while a result beat waits at the output.
// Each selected id goes out as one result beat; the last beat carries
// end_of_list, and a run that selects nothing gives a single beat with
// none_selected set. Loading resumes the cycle after the last beat is taken.
`default_nettype none

module greedy_activity_selection #(
    parameter int MAX_ACTIVITIES = 32,
    parameter int TIME_BITS      = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] start_time,
    input  wire logic [15:0] finish_time,
    input  wire logic [15:0] activity_id,
    input  wire logic        last_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      selected_id,
    output logic             end_of_list,
    output logic             none_selected,
    output logic             overflowed
);

    import gas_pkg::*;

    gas_cmd_t cmd;
    gas_sts_t sts;

    gas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_item),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gas_dp #(
        .MAX_ACTIVITIES (MAX_ACTIVITIES),
        .TIME_BITS      (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .start_time    (start_time),
        .finish_time   (finish_time),
        .activity_id   (activity_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .selected_id   (selected_id),
        .end_of_list   (end_of_list),
        .none_selected (none_selected),
        .overflowed    (overflowed)
    );

endmodule

`default_nettype wire

FILE: sv/gas_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gas_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/gas_ctrl.sv
// Controller state machine: loading, selection walk and result sequencing.
`default_nettype none

module gas_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_last,
    output logic                   in_stall,
    input  wire gas_pkg::gas_sts_t sts,
    output gas_pkg::gas_cmd_t      cmd
);

    import gas_pkg::*;

    gas_state_t state_reg;
    gas_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.chk = 1'b1;
                if (sts.match && sts.pend_valid)
                begin
                    state_next = S_WAIT;
                end
                else if (sts.scan_done)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_LAST;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_WAIT:
            begin
                if (sts.out_taken)
                begin
                    if (sts.scan_end)
                    begin
                        cmd.emit_final = 1'b1;
                        state_next     = S_LAST;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_LAST:
            begin
                if (sts.out_taken)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/gas_dp.sv
// Datapath: activity store, walk counters, pending selection and result register.
`default_nettype none

module gas_dp #(
    parameter int MAX_ACTIVITIES = 32,
    parameter int TIME_BITS      = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gas_pkg::gas_cmd_t cmd,
    output gas_pkg::gas_sts_t      sts,
    input  wire logic [15:0]       start_time,
    input  wire logic [15:0]       finish_time,
    input  wire logic [15:0]       activity_id,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [15:0]            selected_id,
    output logic                   end_of_list,
    output logic                   none_selected,
    output logic                   overflowed
);

    import gas_pkg::*;

    localparam int IW   = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
    localparam int CW   = $clog2(MAX_ACTIVITIES + 1);
    localparam int LW   = CW + 1;
    localparam int CMPW = TIME_BITS + LW;
    localparam int MW   = 2 * TIME_BITS + 16;

    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [LW-1:0]        f_reg, f_next;
    logic [TIME_BITS-1:0] lf_reg, lf_next;
    logic                 pv_reg, pv_next;
    logic [15:0]          pend_reg, pend_next;
    logic                 se_reg, se_next;
    logic                 ov_reg, ov_next;
    logic [15:0]          oid_reg, oid_next;
    logic                 oeol_reg, oeol_next;
    logic                 onone_reg, onone_next;
    logic                 oovf_reg, oovf_next;

    logic                 not_full;
    logic [MW-1:0]        wdata;
    logic [MW-1:0]        rdata;
    logic [TIME_BITS-1:0] rd_start;
    logic [TIME_BITS-1:0] rd_finish;
    logic [15:0]          rd_id;
    logic                 i_last;
    logic                 f_last;
    logic                 match;
    logic                 out_taken;
    logic                 fin_has;
    logic [15:0]          fin_id;

    assign not_full = (count_reg < CW'(MAX_ACTIVITIES));
    assign wdata    = {TIME_BITS'(start_time), TIME_BITS'(finish_time), activity_id};

    gas_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_ACTIVITIES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load && not_full),
        .waddr (count_reg[IW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (i_reg),
        .rdata (rdata)
    );

    assign rd_start  = rdata[MW-1 -: TIME_BITS];
    assign rd_finish = rdata[16 +: TIME_BITS];
    assign rd_id     = rdata[15:0];

    assign i_last    = ((CW'(i_reg) + CW'(1)) == count_reg);
    assign f_last    = ((f_reg + LW'(1)) == {count_reg, 1'b0});
    assign match     = (CMPW'(rd_finish) == CMPW'(f_reg)) && (rd_start >= lf_reg);
    assign out_taken = ov_reg && !out_stall;
    assign fin_has   = pv_reg || (cmd.chk && match);
    assign fin_id    = (cmd.chk && match) ? rd_id : pend_reg;

    assign sts.match      = match;
    assign sts.pend_valid = pv_reg;
    assign sts.scan_done  = i_last && f_last;
    assign sts.scan_end   = se_reg;
    assign sts.out_taken  = out_taken;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        f_next     = f_reg;
        lf_next    = lf_reg;
        pv_next    = pv_reg;
        pend_next  = pend_reg;
        se_next    = se_reg;
        ov_next    = ov_reg;
        oid_next   = oid_reg;
        oeol_next  = oeol_reg;
        onone_next = onone_reg;
        oovf_next  = oovf_reg;

        if (cmd.load)
        begin
            if (not_full)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.start_scan)
        begin
            i_next  = '0;
            f_next  = '0;
            lf_next = '0;
            pv_next = 1'b0;
            se_next = 1'b0;
        end

        if (out_taken)
        begin
            ov_next = 1'b0;
        end

        if (cmd.chk)
        begin
            if (i_last)
            begin
                i_next = '0;
                f_next = f_reg + LW'(1);
            end
            else
            begin
                i_next = i_reg + IW'(1);
            end
            if (i_last && f_last)
            begin
                se_next = 1'b1;
            end
            if (match)
            begin
                lf_next   = rd_finish;
                pend_next = rd_id;
                pv_next   = 1'b1;
                if (pv_reg)
                begin
                    ov_next    = 1'b1;
                    oid_next   = pend_reg;
                    oeol_next  = 1'b0;
                    onone_next = 1'b0;
                    oovf_next  = ovf_reg;
                end
            end
        end

        if (cmd.emit_final)
        begin
            ov_next    = 1'b1;
            oid_next   = fin_has ? fin_id : 16'd0;
            oeol_next  = 1'b1;
            onone_next = !fin_has;
            oovf_next  = ovf_reg;
        end

        if (cmd.finish)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            pv_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            f_reg     <= '0;
            lf_reg    <= '0;
            pv_reg    <= 1'b0;
            se_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            f_reg     <= f_next;
            lf_reg    <= lf_next;
            pv_reg    <= pv_next;
            se_reg    <= se_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        oid_reg   <= oid_next;
        oeol_reg  <= oeol_next;
        onone_reg <= onone_next;
        oovf_reg  <= oovf_next;
    end

    assign out_valid     = ov_reg;
    assign selected_id   = oid_reg;
    assign end_of_list   = oeol_reg;
    assign none_selected = onone_reg;
    assign overflowed    = oovf_reg;

endmodule

`default_nettype wire

FILE: sv/gas_checker.sv
// Port-level assertions for the greedy activity selection block, with bind.
`default_nettype none

module gas_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        last_item,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] selected_id,
    input wire logic        end_of_list,
    input wire logic        none_selected
);

    a_no_load_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result beat is pending");

    a_none_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && none_selected) |-> (end_of_list && (selected_id == 16'd0)))
        else $error("none_selected beat is not a final beat with zero id");

    a_last_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_item) |=> in_stall)
        else $error("input not stalled after the closing beat");

    a_reopen_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && end_of_list) |=> (!in_stall && !out_valid))
        else $error("block did not return to loading after the final beat");

endmodule

bind greedy_activity_selection gas_checker u_gas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .last_item     (last_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .selected_id   (selected_id),
    .end_of_list   (end_of_list),
    .none_selected (none_selected)
);

`default_nettype wire
